// ----- hw/rtl/adsr_pkg.sv -----
// Shared types and constants for the ADSR envelope generator.
// No dependencies; used by adsr_envelope_generator_core.
package adsr_pkg;

    // Field and port widths that the interface fixes
    localparam int LEVEL_W        = 16;
    localparam int PHASE_W        = 3;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int SUSTAIN_W      = 16;

    // Defaults for the top-level parameters
    localparam int DEF_COUNT_BITS = 24;
    localparam int DEF_LEVEL_BITS = 16;

    // Register reset values
    localparam int LEN_RST        = 48;
    localparam int SUSTAIN_RST    = 32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK_LEN  = 2'd0,
        CFG_DECAY_LEN   = 2'd1,
        CFG_SUSTAIN_LVL = 2'd2,
        CFG_RELEASE_LEN = 2'd3
    } cfg_idx_t;

    typedef enum logic [PHASE_W-1:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } stage_t;

    typedef enum logic [1:0] {
        SQ_WAIT,
        SQ_MUL,
        SQ_DIV,
        SQ_PUSH
    } seq_t;

endpackage

// ----- hw/rtl/adsr_envelope_generator_core.sv -----
// Linear ADSR envelope generator: one gate beat in, one level/phase beat out.
// Depends on adsr_pkg.
//
// Each input beat is one audio sample tick. A tick in the middle of an attack,
// decay or release ramp is accepted, multiplied, run through LEVEL_BITS steps
// of the restoring divider that produces one quotient bit per cycle, and then
// loaded into the output register once that is free. Ticks with no ramp step
// (idle, sustain, stage ends) go from accept straight to the output load.
// The divider and multiplier are shared by all three ramps. A new beat may be
// accepted while the previous result still waits in the output register.
// Configuration writes take effect at once and must be done between ticks.
module adsr_envelope_generator_core #(
    parameter int COUNT_BITS = adsr_pkg::DEF_COUNT_BITS,
    parameter int LEVEL_BITS = adsr_pkg::DEF_LEVEL_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [adsr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           note_on,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [adsr_pkg::LEVEL_W-1:0]   level,
    output logic [adsr_pkg::PHASE_W-1:0]   phase
);

    localparam int PROD_W  = COUNT_BITS + LEVEL_BITS;
    localparam int BIT_W   = $clog2(LEVEL_BITS);
    localparam int CDATA_W = (COUNT_BITS > adsr_pkg::CFG_DATA_W) ? COUNT_BITS
                                                                 : adsr_pkg::CFG_DATA_W;
    localparam int SUS_W   = (LEVEL_BITS > adsr_pkg::SUSTAIN_W) ? LEVEL_BITS
                                                                : adsr_pkg::SUSTAIN_W;
    localparam int OUT_W   = (LEVEL_BITS > adsr_pkg::LEVEL_W) ? LEVEL_BITS
                                                              : adsr_pkg::LEVEL_W;
    localparam logic [LEVEL_BITS-1:0] FULL    = {LEVEL_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] LEN_RST = COUNT_BITS'(adsr_pkg::LEN_RST);
    localparam logic [LEVEL_BITS-1:0] SUS_RST =
        (LEVEL_BITS >= adsr_pkg::SUSTAIN_W) ? LEVEL_BITS'(adsr_pkg::SUSTAIN_RST) : FULL;

    // Configuration registers
    logic [COUNT_BITS-1:0] attack_len_reg, decay_len_reg, release_len_reg;
    logic [LEVEL_BITS-1:0] sustain_reg;

    // Envelope state
    adsr_pkg::stage_t      stage_reg, stage_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [LEVEL_BITS-1:0] cur_level_reg, cur_level_next;
    logic [LEVEL_BITS-1:0] rel_start_reg, rel_start_next;

    // Sequencer and shared arithmetic unit
    adsr_pkg::seq_t        seq_reg, seq_next;
    logic [COUNT_BITS-1:0] op_a_reg, op_a_next;
    logic [LEVEL_BITS-1:0] op_b_reg, op_b_next;
    logic [COUNT_BITS-1:0] divisor_reg, divisor_next;
    logic                  invert_reg, invert_next;
    logic [COUNT_BITS-1:0] rem_reg, rem_next;
    logic [LEVEL_BITS-1:0] quo_reg, quo_next;
    logic [BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;

    // Output register
    logic                  out_valid_reg, out_valid_next;
    logic [adsr_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [adsr_pkg::PHASE_W-1:0] out_phase_reg, out_phase_next;

    // Config data conditioning
    logic [CDATA_W-1:0]    cfg_len_ext;
    logic [COUNT_BITS-1:0] cfg_len;
    logic [SUS_W-1:0]      cfg_sus_ext;
    logic [LEVEL_BITS-1:0] cfg_sus;

    // Datapath helpers
    logic [PROD_W-1:0]     product;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   trial_diff;
    logic                  qbit;
    logic [OUT_W-1:0]      level_ext;
    adsr_pkg::stage_t      st_gate;
    logic [COUNT_BITS-1:0] cnt_gate;
    logic [LEVEL_BITS-1:0] rs_gate;

    assign cfg_len_ext = CDATA_W'(cfg_data);
    assign cfg_len     = cfg_len_ext[COUNT_BITS-1:0];
    assign cfg_sus_ext = SUS_W'(cfg_data[adsr_pkg::SUSTAIN_W-1:0]);
    assign cfg_sus     = (cfg_sus_ext > SUS_W'(FULL)) ? FULL : cfg_sus_ext[LEVEL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg  <= LEN_RST;
            decay_len_reg   <= LEN_RST;
            release_len_reg <= LEN_RST;
            sustain_reg     <= SUS_RST;
        end
        else if (cfg_we)
        begin
            case (adsr_pkg::cfg_idx_t'(cfg_index))
                adsr_pkg::CFG_ATTACK_LEN:  attack_len_reg  <= cfg_len;
                adsr_pkg::CFG_DECAY_LEN:   decay_len_reg   <= cfg_len;
                adsr_pkg::CFG_SUSTAIN_LVL: sustain_reg     <= cfg_sus;
                adsr_pkg::CFG_RELEASE_LEN: release_len_reg <= cfg_len;
                default: ;
            endcase
        end
    end

    assign in_ready  = (seq_reg == adsr_pkg::SQ_WAIT);
    assign out_valid = out_valid_reg;
    assign level     = out_level_reg;
    assign phase     = out_phase_reg;

    // Shared multiply, registered into the divider's remainder/quotient pair
    assign product    = PROD_W'(op_a_reg) * PROD_W'(op_b_reg);
    // One restoring division step
    assign trial      = {rem_reg, quo_reg[LEVEL_BITS-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign qbit       = (trial >= {1'b0, divisor_reg});
    assign level_ext  = OUT_W'(cur_level_reg);

    // Gate transition, applied before the stage runs
    always_comb
    begin
        st_gate  = stage_reg;
        cnt_gate = count_reg;
        rs_gate  = rel_start_reg;
        if (note_on && stage_reg == adsr_pkg::ST_IDLE)
        begin
            st_gate  = adsr_pkg::ST_ATTACK;
            cnt_gate = '0;
        end
        else if (!note_on && (stage_reg inside {adsr_pkg::ST_ATTACK, adsr_pkg::ST_DECAY,
                                                adsr_pkg::ST_SUSTAIN}))
        begin
            st_gate  = adsr_pkg::ST_RELEASE;
            cnt_gate = '0;
            rs_gate  = cur_level_reg;
        end
    end

    always_comb
    begin
        seq_next       = seq_reg;
        stage_next     = stage_reg;
        count_next     = count_reg;
        cur_level_next = cur_level_reg;
        rel_start_next = rel_start_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        divisor_next   = divisor_reg;
        invert_next    = invert_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_level_next = out_level_reg;
        out_phase_next = out_phase_reg;

        case (seq_reg)
            adsr_pkg::SQ_WAIT:
            begin
                if (in_valid)
                begin
                    rel_start_next = rs_gate;
                    stage_next     = st_gate;
                    count_next     = cnt_gate;
                    seq_next       = adsr_pkg::SQ_PUSH;
                    case (st_gate)
                        adsr_pkg::ST_ATTACK:
                        begin
                            if (cnt_gate < attack_len_reg)
                            begin
                                op_a_next    = cnt_gate;
                                op_b_next    = FULL;
                                divisor_next = attack_len_reg;
                                invert_next  = 1'b0;
                                count_next   = cnt_gate + 1'b1;
                                seq_next     = adsr_pkg::SQ_MUL;
                            end
                            else
                            begin
                                cur_level_next = FULL;
                                stage_next     = adsr_pkg::ST_DECAY;
                                count_next     = '0;
                            end
                        end
                        adsr_pkg::ST_DECAY:
                        begin
                            if (cnt_gate < decay_len_reg)
                            begin
                                op_a_next    = cnt_gate;
                                op_b_next    = FULL - sustain_reg;
                                divisor_next = decay_len_reg;
                                invert_next  = 1'b1;
                                count_next   = cnt_gate + 1'b1;
                                seq_next     = adsr_pkg::SQ_MUL;
                            end
                            else
                            begin
                                cur_level_next = sustain_reg;
                                stage_next     = adsr_pkg::ST_SUSTAIN;
                                count_next     = '0;
                            end
                        end
                        adsr_pkg::ST_SUSTAIN:
                        begin
                            cur_level_next = sustain_reg;
                        end
                        adsr_pkg::ST_RELEASE:
                        begin
                            if (cnt_gate < release_len_reg)
                            begin
                                op_a_next    = release_len_reg - cnt_gate;
                                op_b_next    = rs_gate;
                                divisor_next = release_len_reg;
                                invert_next  = 1'b0;
                                count_next   = cnt_gate + 1'b1;
                                seq_next     = adsr_pkg::SQ_MUL;
                            end
                            else
                            begin
                                cur_level_next = '0;
                                stage_next     = adsr_pkg::ST_IDLE;
                                count_next     = '0;
                            end
                        end
                        default:
                        begin
                            stage_next     = adsr_pkg::ST_IDLE;
                            cur_level_next = '0;
                        end
                    endcase
                end
            end
            adsr_pkg::SQ_MUL:
            begin
                // Quotient fits LEVEL_BITS, so the upper product bits start below the divisor
                rem_next     = product[PROD_W-1:LEVEL_BITS];
                quo_next     = product[LEVEL_BITS-1:0];
                bit_cnt_next = BIT_W'(LEVEL_BITS - 1);
                seq_next     = adsr_pkg::SQ_DIV;
            end
            adsr_pkg::SQ_DIV:
            begin
                rem_next     = qbit ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                quo_next     = {quo_reg[LEVEL_BITS-2:0], qbit};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    cur_level_next = invert_reg ? FULL - {quo_reg[LEVEL_BITS-2:0], qbit}
                                                : {quo_reg[LEVEL_BITS-2:0], qbit};
                    seq_next       = adsr_pkg::SQ_PUSH;
                end
            end
            adsr_pkg::SQ_PUSH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_level_next = level_ext[adsr_pkg::LEVEL_W-1:0];
                    out_phase_next = stage_reg;
                    seq_next       = adsr_pkg::SQ_WAIT;
                end
            end
            default:
            begin
                seq_next = adsr_pkg::SQ_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= adsr_pkg::SQ_WAIT;
            stage_reg     <= adsr_pkg::ST_IDLE;
            count_reg     <= '0;
            cur_level_reg <= '0;
            rel_start_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            stage_reg     <= stage_next;
            count_reg     <= count_next;
            cur_level_reg <= cur_level_next;
            rel_start_reg <= rel_start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        divisor_reg   <= divisor_next;
        invert_reg    <= invert_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        bit_cnt_reg   <= bit_cnt_next;
        out_level_reg <= out_level_next;
        out_phase_reg <= out_phase_next;
    end

endmodule
